// ===== rtl/sst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes of the subscriber session table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int unsigned TableEntries = 64;

    localparam int unsigned CmdW    = 4;
    localparam int unsigned ImsiW   = 50;
    localparam int unsigned IpW     = 32;
    localparam int unsigned BytesW  = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned PortW   = 16;
    localparam int unsigned StatusW = 3;
    localparam int unsigned PktW    = 48;
    localparam int unsigned CntW    = 56;

    typedef enum logic [CmdW-1:0] {
        CMD_ATTACH_START    = 4'd0,
        CMD_ATTACH_COMPLETE = 4'd1,
        CMD_ATTACH_FAIL     = 4'd2,
        CMD_DETACH_START    = 4'd3,
        CMD_DETACH_COMPLETE = 4'd4,
        CMD_BIND_PEER       = 4'd5,
        CMD_LOOKUP_IMSI     = 4'd6,
        CMD_LOOKUP_IP       = 4'd7,
        CMD_UPLINK          = 4'd8,
        CMD_DOWNLINK        = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_ATTACHING = 2'd1,
        ST_ATTACHED  = 2'd2,
        ST_DETACHING = 2'd3
    } t_slot_state;

    typedef enum logic [StatusW-1:0] {
        S_OK           = 3'd0,
        S_NOT_FOUND    = 3'd1,
        S_IMSI_USED    = 3'd2,
        S_IP_USED      = 3'd3,
        S_FULL         = 3'd4,
        S_NOT_ATTACHED = 3'd5
    } t_status;

    // One command word as it travels from the front to the back.
    typedef struct packed {
        logic [CmdW-1:0]   cmd;
        logic [ImsiW-1:0]  imsi;
        logic [IpW-1:0]    ue_ip;
        logic [BytesW-1:0] byte_count;
        logic [TimeW-1:0]  now_time;
        logic [IpW-1:0]    peer_addr;
        logic [PortW-1:0]  peer_port;
    } t_cmd_word;

    // Entry body held in the payload memory.
    typedef struct packed {
        logic [PktW-1:0]  up_packets;
        logic [CntW-1:0]  up_bytes;
        logic [PktW-1:0]  down_packets;
        logic [CntW-1:0]  down_bytes;
        logic [TimeW-1:0] last_seen;
        logic             peer_bound;
        logic [IpW-1:0]   peer_addr;
        logic [PortW-1:0] peer_port;
    } t_body;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [1:0]         state;
        logic [ImsiW-1:0]   imsi;
        logic [IpW-1:0]     ip;
        t_body              body;
    } t_result;

endpackage

// ===== rtl/sst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/sst_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sst_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sst_pkg::t_cmd_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output sst_pkg::t_cmd_word o_word
);
    import sst_pkg::*;

    t_cmd_word  r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_buf[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== rtl/sst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_front
// Input stage: a register that takes command words from the input port and
// hands them on to the command queue.
// ----------------------------------------------------------------------------
module sst_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sst_pkg::t_cmd_word         i_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output sst_pkg::t_cmd_word         o_word
);
    import sst_pkg::*;

    logic      r_valid;
    t_cmd_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end
endmodule

// ===== rtl/sst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_back
// Execution engine: scans the key table one entry a cycle, reads the
// matched entry body, applies the command and writes it back.
// ----------------------------------------------------------------------------
module sst_back #(
    parameter int unsigned TABLE_ENTRIES = sst_pkg::TableEntries
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sst_pkg::t_cmd_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output sst_pkg::t_result    o_result
);
    import sst_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned KW = 2 + ImsiW + IpW;
    localparam logic [CW-1:0] LastIdx = CW'(TABLE_ENTRIES - 1);
    localparam logic [PktW-1:0] PktMax = '1;
    localparam logic [CntW-1:0] CntMax = '1;

    typedef enum logic [5:0] {
        FS_IDLE  = 6'b000001,
        FS_SCAN  = 6'b000010,
        FS_READ  = 6'b000100,
        FS_WAIT  = 6'b001000,
        FS_APPLY = 6'b010000,
        FS_OUT   = 6'b100000
    } t_fsm;

    t_fsm          r_fsm;
    t_cmd_word     r_cmd;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_addr;
    logic          r_lag;
    logic          r_imsi_hit, r_ip_hit, r_free_hit;
    logic [AW-1:0] r_imsi_idx, r_ip_idx, r_free_idx;
    logic [TABLE_ENTRIES-1:0] r_used;
    logic          r_out_valid;
    t_result       r_res;

    logic          w_key_we, w_body_we;
    logic [AW-1:0] w_addr;
    logic [KW-1:0] w_key_wd, w_key_rd;
    t_body         w_body_wd, w_body_rd;
    logic [ImsiW-1:0] w_rd_imsi;
    logic [IpW-1:0]   w_rd_ip;
    logic          w_use_ip;
    logic          w_hit;
    logic [AW-1:0] w_hit_idx;
    logic [1:0]    w_hit_state;
    logic          w_scan_used;
    t_body         n_body;
    t_result       n_res;
    logic [1:0]    n_state;
    logic          n_used, n_body_we, n_key_we;
    logic [PktW:0] w_pkt_sum;
    logic [CntW:0] w_cnt_sum;
    logic [PktW-1:0] w_pkt_old;
    logic [CntW-1:0] w_cnt_old;

    // The key memory also holds the state of each entry in its top two bits.
    assign w_hit_state = w_key_rd[KW-1:KW-2];
    assign w_rd_imsi = w_key_rd[ImsiW+IpW-1:IpW];
    assign w_rd_ip   = w_key_rd[IpW-1:0];
    assign o_ready   = (r_fsm == FS_IDLE);
    assign o_valid   = r_out_valid;
    assign o_result  = r_res;

    assign w_use_ip = (r_cmd.cmd == CMD_BIND_PEER) || (r_cmd.cmd == CMD_LOOKUP_IP) ||
                      (r_cmd.cmd == CMD_UPLINK) || (r_cmd.cmd == CMD_DOWNLINK);

    // Attach start resolves to the IMSI match, else the IP match, else a free slot.
    always_comb begin
        w_hit = 1'b0;
        w_hit_idx = r_imsi_idx;
        if (r_cmd.cmd == CMD_ATTACH_START) begin
            priority if (r_imsi_hit) begin
                w_hit = 1'b1; w_hit_idx = r_imsi_idx;
            end else if (r_ip_hit) begin
                w_hit = 1'b1; w_hit_idx = r_ip_idx;
            end else begin
                w_hit = r_free_hit; w_hit_idx = r_free_idx;
            end
        end else if (w_use_ip) begin
            w_hit = r_ip_hit; w_hit_idx = r_ip_idx;
        end else if (r_cmd.cmd <= CMD_LOOKUP_IMSI) begin
            w_hit = r_imsi_hit; w_hit_idx = r_imsi_idx;
        end
    end

    // Memory address: scan index during the scan, matched slot afterward.
    assign w_addr = (r_fsm == FS_SCAN) ? r_idx[AW-1:0] : w_hit_idx;
    assign w_scan_used = r_used[r_addr];

    assign w_pkt_old = (r_cmd.cmd == CMD_UPLINK) ? w_body_rd.up_packets
                                                 : w_body_rd.down_packets;
    assign w_cnt_old = (r_cmd.cmd == CMD_UPLINK) ? w_body_rd.up_bytes
                                                 : w_body_rd.down_bytes;
    assign w_pkt_sum = {1'b0, w_pkt_old} + (PktW+1)'(1);
    assign w_cnt_sum = {1'b0, w_cnt_old} + (CntW+1)'(r_cmd.byte_count);

    always_comb begin
        n_body    = w_body_rd;
        n_state   = w_hit_state;
        n_used    = 1'b1;
        n_body_we = 1'b0;
        n_key_we  = 1'b0;
        n_res     = '0;
        n_res.status = S_NOT_FOUND;
        if (w_hit) begin
            n_res.status = S_OK;
            unique case (r_cmd.cmd)
                CMD_ATTACH_START: begin
                    if (r_imsi_hit) begin
                        if (!(w_rd_ip == r_cmd.ue_ip && w_hit_state == ST_ATTACHED))
                            n_res.status = S_IMSI_USED;
                    end else if (r_ip_hit) begin
                        n_res.status = S_IP_USED;
                    end else begin
                        n_body = '0;
                        n_state = ST_ATTACHING;
                        n_body_we = 1'b1;
                        n_key_we = 1'b1;
                    end
                end
                CMD_ATTACH_COMPLETE: n_state = ST_ATTACHED;
                CMD_DETACH_START:    n_state = ST_DETACHING;
                CMD_ATTACH_FAIL, CMD_DETACH_COMPLETE: n_used = 1'b0;
                CMD_BIND_PEER, CMD_LOOKUP_IP: begin
                    if (w_hit_state != ST_ATTACHED) begin
                        n_res.status = S_NOT_ATTACHED;
                    end else if (r_cmd.cmd == CMD_BIND_PEER) begin
                        n_body.peer_bound = 1'b1;
                        n_body.peer_addr  = r_cmd.peer_addr;
                        n_body.peer_port  = r_cmd.peer_port;
                        n_body.last_seen  = r_cmd.now_time;
                        n_body_we = 1'b1;
                    end
                end
                CMD_UPLINK, CMD_DOWNLINK: begin
                    if (r_cmd.cmd == CMD_UPLINK) begin
                        n_body.up_packets = w_pkt_sum[PktW] ? PktMax : w_pkt_sum[PktW-1:0];
                        n_body.up_bytes   = w_cnt_sum[CntW] ? CntMax : w_cnt_sum[CntW-1:0];
                    end else begin
                        n_body.down_packets = w_pkt_sum[PktW] ? PktMax : w_pkt_sum[PktW-1:0];
                        n_body.down_bytes   = w_cnt_sum[CntW] ? CntMax : w_cnt_sum[CntW-1:0];
                    end
                    n_body.last_seen = r_cmd.now_time;
                    n_body_we = 1'b1;
                end
                default: ;
            endcase
            // Freeing commands report the entry as it stood before.
            n_res.state = n_used ? n_state : w_hit_state;
            n_res.imsi  = n_key_we ? r_cmd.imsi : w_rd_imsi;
            n_res.ip    = n_key_we ? r_cmd.ue_ip : w_rd_ip;
            n_res.body  = n_body;
        end else if (r_cmd.cmd == CMD_ATTACH_START) begin
            n_res.status = S_FULL;
        end
    end

    // Every matched entry has its state and keys written back.
    assign w_key_wd  = {n_state, n_key_we ? r_cmd.imsi : w_rd_imsi,
                        n_key_we ? r_cmd.ue_ip : w_rd_ip};
    assign w_key_we  = (r_fsm == FS_APPLY) && w_hit;
    assign w_body_we = (r_fsm == FS_APPLY) && n_body_we;
    assign w_body_wd = n_body;

    sst_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .i_clk(i_clk), .i_we(w_key_we), .i_addr(w_addr),
        .i_wdata(w_key_wd), .o_rdata(w_key_rd)
    );

    sst_ram #(.WIDTH($bits(t_body)), .DEPTH(TABLE_ENTRIES)) u_body_ram (
        .i_clk(i_clk), .i_we(w_body_we), .i_addr(w_addr),
        .i_wdata(w_body_wd), .o_rdata(w_body_rd)
    );

    always_ff @(posedge i_clk) begin
        if (r_fsm == FS_IDLE && i_valid) begin
            r_cmd <= i_word;
        end
        if (r_fsm == FS_APPLY) begin
            r_res <= n_res;
        end
        r_addr <= w_addr;
        if (!i_rst_n) begin
            r_fsm       <= FS_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_lag       <= 1'b0;
            r_idx       <= '0;
            r_imsi_hit  <= 1'b0;
            r_ip_hit    <= 1'b0;
            r_free_hit  <= 1'b0;
            r_imsi_idx  <= '0;
            r_ip_idx    <= '0;
            r_free_idx  <= '0;
        end else begin
            unique case (r_fsm)
                FS_IDLE: begin
                    if (i_valid) begin
                        r_idx      <= '0;
                        r_lag      <= 1'b0;
                        r_imsi_hit <= 1'b0;
                        r_ip_hit   <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_fsm      <= FS_SCAN;
                    end
                end
                FS_SCAN: begin
                    // Read data arrives in the cycle after its address.
                    r_lag <= 1'b1;
                    if (r_lag) begin
                        if (w_scan_used && !r_imsi_hit && w_rd_imsi == r_cmd.imsi) begin
                            r_imsi_hit <= 1'b1; r_imsi_idx <= r_addr;
                        end
                        if (w_scan_used && !r_ip_hit && w_rd_ip == r_cmd.ue_ip) begin
                            r_ip_hit <= 1'b1; r_ip_idx <= r_addr;
                        end
                        if (!w_scan_used && !r_free_hit) begin
                            r_free_hit <= 1'b1; r_free_idx <= r_addr;
                        end
                    end
                    if (r_lag && r_addr == LastIdx[AW-1:0]) begin
                        r_fsm <= FS_READ;
                    end else if (r_idx != LastIdx) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                FS_READ:  r_fsm <= FS_WAIT;
                FS_WAIT:  r_fsm <= FS_APPLY;
                FS_APPLY: begin
                    if (w_hit && (r_cmd.cmd == CMD_ATTACH_FAIL ||
                                  r_cmd.cmd == CMD_DETACH_COMPLETE ||
                                  (r_cmd.cmd == CMD_ATTACH_START && n_key_we))) begin
                        r_used[w_hit_idx] <= n_used;
                    end
                    r_out_valid <= 1'b1;
                    r_fsm <= FS_OUT;
                end
                FS_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        r_fsm <= FS_IDLE;
                    end
                end
                default: r_fsm <= FS_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/subscriber_session_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subscriber_session_table_unit
// Session table keyed by IMSI and IPv4 address, with one result per command.
// ----------------------------------------------------------------------------
// Each command word goes through the execution engine in order: it is
// accepted, the key table is scanned one entry per cycle through the single
// port of the key memory, whose read is registered, then come a read, a wait
// and an apply of the matched entry, and the result is presented until it is
// taken. A front register and a two-word queue take further commands while
// one is executing.
module subscriber_session_table_unit #(
    parameter int unsigned TABLE_ENTRIES = sst_pkg::TableEntries
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sst_pkg::CmdW-1:0]      i_command,
    input  logic [sst_pkg::ImsiW-1:0]     i_imsi,
    input  logic [sst_pkg::IpW-1:0]       i_ue_ip,
    input  logic [sst_pkg::BytesW-1:0]    i_byte_count,
    input  logic [sst_pkg::TimeW-1:0]     i_now_time,
    input  logic [sst_pkg::IpW-1:0]       i_peer_addr,
    input  logic [sst_pkg::PortW-1:0]     i_peer_port,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sst_pkg::StatusW-1:0]   o_status,
    output logic [1:0]                    o_found_state,
    output logic [sst_pkg::ImsiW-1:0]     o_found_imsi,
    output logic [sst_pkg::IpW-1:0]       o_found_ip,
    output logic [sst_pkg::PktW-1:0]      o_up_packets,
    output logic [sst_pkg::CntW-1:0]      o_up_bytes,
    output logic [sst_pkg::PktW-1:0]      o_down_packets,
    output logic [sst_pkg::CntW-1:0]      o_down_bytes,
    output logic [sst_pkg::TimeW-1:0]     o_last_seen,
    output logic                          o_peer_is_bound,
    output logic [sst_pkg::IpW-1:0]       o_bound_addr,
    output logic [sst_pkg::PortW-1:0]     o_bound_port
);
    import sst_pkg::*;

    t_cmd_word w_in, w_f, w_q;
    logic      w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    t_result   w_res;

    assign w_in = '{cmd: i_command, imsi: i_imsi, ue_ip: i_ue_ip,
                    byte_count: i_byte_count, now_time: i_now_time,
                    peer_addr: i_peer_addr, peer_port: i_peer_port};

    sst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(w_in),
        .o_valid(w_f_valid), .i_ready(w_f_ready), .o_word(w_f)
    );

    sst_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_word(w_f),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_word(w_q)
    );

    sst_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_word(w_q),
        .o_valid(o_valid), .i_ready(i_ready), .o_result(w_res)
    );

    assign o_status        = w_res.status;
    assign o_found_state   = w_res.state;
    assign o_found_imsi    = w_res.imsi;
    assign o_found_ip      = w_res.ip;
    assign o_up_packets    = w_res.body.up_packets;
    assign o_up_bytes      = w_res.body.up_bytes;
    assign o_down_packets  = w_res.body.down_packets;
    assign o_down_bytes    = w_res.body.down_bytes;
    assign o_last_seen     = w_res.body.last_seen;
    assign o_peer_is_bound = w_res.body.peer_bound;
    assign o_bound_addr    = w_res.body.peer_addr;
    assign o_bound_port    = w_res.body.peer_port;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subscriber session table unit.
// A short directed table walks the error codes other than S_FULL and the field extremes.
// Random session lifecycles follow: attach, complete, bind, traffic and
// detach over a key pool larger than the table, with noise mixed in.
// A local copy of the table predicts every result word, which is then
// checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
    import sst_pkg::*;

    localparam int NumRandom = 1600;
    localparam int PoolSize  = 100;
    localparam logic [ImsiW-1:0] ImsiMax = 50'd999999999999999;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CmdW-1:0]     i_command;
    logic [ImsiW-1:0]    i_imsi;
    logic [IpW-1:0]      i_ue_ip;
    logic [BytesW-1:0]   i_byte_count;
    logic [TimeW-1:0]    i_now_time;
    logic [IpW-1:0]      i_peer_addr;
    logic [PortW-1:0]    i_peer_port;
    logic                o_valid;
    logic                i_ready;
    logic [StatusW-1:0]  o_status;
    logic [1:0]          o_found_state;
    logic [ImsiW-1:0]    o_found_imsi;
    logic [IpW-1:0]      o_found_ip;
    logic [PktW-1:0]     o_up_packets;
    logic [CntW-1:0]     o_up_bytes;
    logic [PktW-1:0]     o_down_packets;
    logic [CntW-1:0]     o_down_bytes;
    logic [TimeW-1:0]    o_last_seen;
    logic                o_peer_is_bound;
    logic [IpW-1:0]      o_bound_addr;
    logic [PortW-1:0]    o_bound_port;

    subscriber_session_table_unit i_dut (.*);

    // Local copy of the session table.
    t_slot_state     tbl_state [TableEntries];
    logic [ImsiW-1:0] tbl_imsi [TableEntries];
    logic [IpW-1:0]   tbl_ip   [TableEntries];
    t_body            tbl_body [TableEntries];

    t_result          pending_results[$];
    int               errors;
    logic [ImsiW-1:0] pool_imsi [PoolSize];
    logic [IpW-1:0]   pool_ip   [PoolSize];

    typedef struct {
        t_cmd_word word;
        bit        has_status;
        t_status   status;
    } t_row;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    function automatic int slot_by_imsi(input logic [ImsiW-1:0] key);
        for (int i = 0; i < TableEntries; i++) begin
            if (tbl_state[i] != ST_FREE && tbl_imsi[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int slot_by_ip(input logic [IpW-1:0] key);
        for (int i = 0; i < TableEntries; i++) begin
            if (tbl_state[i] != ST_FREE && tbl_ip[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void clear_entry(input int i);
        tbl_state[i] = ST_FREE;
        tbl_imsi[i]  = '0;
        tbl_ip[i]    = '0;
        tbl_body[i]  = '0;
    endfunction

    function automatic t_result entry_view(input t_status st, input int i);
        t_result r;
        r = '0;
        r.status = st;
        if (i >= 0) begin
            r.state = tbl_state[i];
            r.imsi  = tbl_imsi[i];
            r.ip    = tbl_ip[i];
            r.body  = tbl_body[i];
        end
        return r;
    endfunction

    function automatic logic [PktW-1:0] sat_pkt(input logic [PktW-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    function automatic logic [CntW-1:0] sat_cnt(input logic [CntW-1:0] a,
                                               input logic [BytesW-1:0] b);
        logic [CntW:0] s;
        s = {1'b0, a} + b;
        return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
    endfunction

    // Applies one command to the local table and gives the result word.
    function automatic t_result session_update(input t_cmd_word w);
        int i;
        int j;
        t_result r;
        case (w.cmd)
            CMD_ATTACH_START: begin
                i = slot_by_imsi(w.imsi);
                if (i >= 0) begin
                    if (tbl_ip[i] == w.ue_ip && tbl_state[i] == ST_ATTACHED)
                        return entry_view(S_OK, i);
                    return entry_view(S_IMSI_USED, i);
                end
                i = slot_by_ip(w.ue_ip);
                if (i >= 0) return entry_view(S_IP_USED, i);
                j = -1;
                for (int k = TableEntries - 1; k >= 0; k--) begin
                    if (tbl_state[k] == ST_FREE) j = k;
                end
                if (j < 0) return entry_view(S_FULL, -1);
                clear_entry(j);
                tbl_imsi[j]  = w.imsi;
                tbl_ip[j]    = w.ue_ip;
                tbl_state[j] = ST_ATTACHING;
                return entry_view(S_OK, j);
            end
            CMD_ATTACH_COMPLETE, CMD_DETACH_START, CMD_LOOKUP_IMSI: begin
                i = slot_by_imsi(w.imsi);
                if (i < 0) return entry_view(S_NOT_FOUND, -1);
                if (w.cmd == CMD_ATTACH_COMPLETE) tbl_state[i] = ST_ATTACHED;
                if (w.cmd == CMD_DETACH_START) tbl_state[i] = ST_DETACHING;
                return entry_view(S_OK, i);
            end
            CMD_ATTACH_FAIL, CMD_DETACH_COMPLETE: begin
                i = slot_by_imsi(w.imsi);
                if (i < 0) return entry_view(S_NOT_FOUND, -1);
                r = entry_view(S_OK, i);
                clear_entry(i);
                return r;
            end
            CMD_BIND_PEER, CMD_LOOKUP_IP: begin
                i = slot_by_ip(w.ue_ip);
                if (i < 0) return entry_view(S_NOT_FOUND, -1);
                if (tbl_state[i] != ST_ATTACHED) return entry_view(S_NOT_ATTACHED, i);
                if (w.cmd == CMD_BIND_PEER) begin
                    tbl_body[i].peer_bound = 1'b1;
                    tbl_body[i].peer_addr  = w.peer_addr;
                    tbl_body[i].peer_port  = w.peer_port;
                    tbl_body[i].last_seen  = w.now_time;
                end
                return entry_view(S_OK, i);
            end
            CMD_UPLINK, CMD_DOWNLINK: begin
                i = slot_by_ip(w.ue_ip);
                if (i < 0) return entry_view(S_NOT_FOUND, -1);
                if (w.cmd == CMD_UPLINK) begin
                    tbl_body[i].up_packets = sat_pkt(tbl_body[i].up_packets);
                    tbl_body[i].up_bytes   = sat_cnt(tbl_body[i].up_bytes, w.byte_count);
                end else begin
                    tbl_body[i].down_packets = sat_pkt(tbl_body[i].down_packets);
                    tbl_body[i].down_bytes   = sat_cnt(tbl_body[i].down_bytes,
                                                       w.byte_count);
                end
                tbl_body[i].last_seen = w.now_time;
                return entry_view(S_OK, i);
            end
            default: return entry_view(S_NOT_FOUND, -1);
        endcase
    endfunction

    function automatic logic [ImsiW-1:0] random_imsi();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ImsiW'(r % 64'd1000000000000000);
    endfunction

    // Drives one word, keeps valid high until accepted, then predicts.
    task automatic send_word(input t_cmd_word w, input bit has_status,
                             input t_status status);
        t_result r;
        i_command    <= w.cmd;
        i_imsi       <= w.imsi;
        i_ue_ip      <= w.ue_ip;
        i_byte_count <= w.byte_count;
        i_now_time   <= w.now_time;
        i_peer_addr  <= w.peer_addr;
        i_peer_port  <= w.peer_port;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        r = session_update(w);
        if (has_status && r.status != status)
            report_mismatch("directed status", r.status, status);
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    function automatic t_cmd_word make_word(input t_cmd c, input logic [ImsiW-1:0] imsi,
                                            input logic [IpW-1:0] ip);
        t_cmd_word w;
        w.cmd        = c;
        w.imsi       = imsi;
        w.ue_ip      = ip;
        w.byte_count = BytesW'($urandom);
        w.now_time   = $urandom;
        w.peer_addr  = $urandom;
        w.peer_port  = PortW'($urandom);
        return w;
    endfunction

    // Picks the next step of a session's life, or noise.
    function automatic t_cmd_word random_word(input bit draining);
        int k;
        int i;
        t_cmd_word w;
        k = $urandom_range(PoolSize - 1);
        w = make_word(CMD_LOOKUP_IMSI, pool_imsi[k], pool_ip[k]);
        if ($urandom_range(99) < 15) begin
            w.cmd = CmdW'($urandom_range(15));
            if ($urandom_range(1)) w.imsi = random_imsi();
            if ($urandom_range(1)) w.ue_ip = pool_ip[$urandom_range(PoolSize - 1)];
            return w;
        end
        i = slot_by_imsi(pool_imsi[k]);
        if (i < 0) begin
            w.cmd = (draining && $urandom_range(3) != 0) ? CMD_LOOKUP_IP : CMD_ATTACH_START;
            return w;
        end
        case (tbl_state[i])
            ST_ATTACHING: w.cmd = ($urandom_range(4) == 0) ? CMD_ATTACH_FAIL :
                                  ($urandom_range(3) == 0) ? CMD_UPLINK : CMD_ATTACH_COMPLETE;
            ST_ATTACHED: begin
                case ($urandom_range(draining ? 9 : 11))
                    0, 1:    w.cmd = CMD_BIND_PEER;
                    2, 3:    w.cmd = CMD_UPLINK;
                    4, 5:    w.cmd = CMD_DOWNLINK;
                    6:       w.cmd = CMD_LOOKUP_IP;
                    7:       w.cmd = CMD_ATTACH_START;
                    8, 9:    w.cmd = CMD_DETACH_START;
                    default: w.cmd = CMD_LOOKUP_IMSI;
                endcase
            end
            default: w.cmd = ($urandom_range(3) == 0) ? CMD_DOWNLINK : CMD_DETACH_COMPLETE;
        endcase
        return w;
    endfunction

    // Receiver stall pattern: the mode, chosen at random, is always ready, randomly ready or a rare toggle.
    initial begin
        int mode;
        i_ready = 1'b0;
        forever begin
            mode = $urandom_range(2);
            repeat ($urandom_range(100, 400)) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(9) < 6);
                    default: i_ready <= ($urandom_range(31) == 0) ? ~i_ready : i_ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_status, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_found_state != want.state)
                    report_mismatch("found_state", o_found_state, want.state);
                if (o_found_imsi != want.imsi)
                    report_mismatch("found_imsi", o_found_imsi, want.imsi);
                if (o_found_ip != want.ip)
                    report_mismatch("found_ip", o_found_ip, want.ip);
                if (o_up_packets != want.body.up_packets)
                    report_mismatch("up_packets", o_up_packets, want.body.up_packets);
                if (o_up_bytes != want.body.up_bytes)
                    report_mismatch("up_bytes", o_up_bytes, want.body.up_bytes);
                if (o_down_packets != want.body.down_packets)
                    report_mismatch("down_packets", o_down_packets, want.body.down_packets);
                if (o_down_bytes != want.body.down_bytes)
                    report_mismatch("down_bytes", o_down_bytes, want.body.down_bytes);
                if (o_last_seen != want.body.last_seen)
                    report_mismatch("last_seen", o_last_seen, want.body.last_seen);
                if (o_peer_is_bound != want.body.peer_bound)
                    report_mismatch("peer_is_bound", o_peer_is_bound, want.body.peer_bound);
                if (o_bound_addr != want.body.peer_addr)
                    report_mismatch("bound_addr", o_bound_addr, want.body.peer_addr);
                if (o_bound_port != want.body.peer_port)
                    report_mismatch("bound_port", o_bound_port, want.body.peer_port);
            end
        end
    end

    initial begin
        #60ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_row      rows[$];
        t_row      row;
        t_cmd_word w;
        int        burst;
        bit        draining;

        errors       = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = '0;
        i_imsi       = '0;
        i_ue_ip      = '0;
        i_byte_count = '0;
        i_now_time   = '0;
        i_peer_addr  = '0;
        i_peer_port  = '0;
        for (int i = 0; i < TableEntries; i++) clear_entry(i);
        pool_imsi[0] = ImsiMax;
        pool_ip[0]   = '1;
        pool_imsi[1] = '0;
        pool_ip[1]   = '0;
        for (int k = 2; k < PoolSize; k++) begin
            pool_imsi[k] = random_imsi();
            pool_ip[k]   = $urandom;
        end

        // Directed table: error codes, extremes and the attached repeat.
        row.has_status = 1'b1;
        row.word = make_word(CMD_LOOKUP_IMSI, '0, '0);      row.status = S_NOT_FOUND;
        rows.push_back(row);
        row.word = make_word(CMD_LOOKUP_IP, '0, '0);        row.status = S_NOT_FOUND;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_START, ImsiMax, '1); row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_START, '0, '0);     row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_START, ImsiMax, 5); row.status = S_IMSI_USED;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_START, 7, '1);      row.status = S_IP_USED;
        rows.push_back(row);
        row.word = make_word(CMD_BIND_PEER, 7, '1);         row.status = S_NOT_ATTACHED;
        rows.push_back(row);
        row.word = make_word(CMD_LOOKUP_IP, 7, '1);         row.status = S_NOT_ATTACHED;
        rows.push_back(row);
        row.word = make_word(CMD_UPLINK, 7, '1);            row.status = S_OK;
        row.word.byte_count = '1;
        row.word.now_time   = '1;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_COMPLETE, ImsiMax, 0); row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_START, ImsiMax, '1);   row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_BIND_PEER, 3, '1);         row.status = S_OK;
        row.word.peer_addr = '1;
        row.word.peer_port = '1;
        row.word.now_time  = '0;
        rows.push_back(row);
        row.word = make_word(CMD_DOWNLINK, 3, '0);          row.status = S_OK;
        row.word.byte_count = '1;
        rows.push_back(row);
        row.word = make_word(CMD_BIND_PEER, 3, '1);         row.status = S_OK;
        row.word.peer_addr = '0;
        row.word.peer_port = '0;
        rows.push_back(row);
        row.word = make_word(CMD_LOOKUP_IP, 3, '1);         row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_DETACH_START, ImsiMax, 0); row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_LOOKUP_IMSI, ImsiMax, 0);  row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_DETACH_COMPLETE, ImsiMax, 0); row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_FAIL, '0, 0);       row.status = S_OK;
        rows.push_back(row);
        row.word = make_word(CMD_ATTACH_COMPLETE, '0, 0);   row.status = S_NOT_FOUND;
        rows.push_back(row);
        row.word = make_word(CMD_DETACH_COMPLETE, ImsiMax, 0); row.status = S_NOT_FOUND;
        rows.push_back(row);
        row.word = make_word(CMD_DOWNLINK, 0, 1);           row.status = S_NOT_FOUND;
        rows.push_back(row);
        row.word = make_word(CMD_LOOKUP_IMSI, 0, 0);        row.status = S_NOT_FOUND;
        row.word.cmd = 4'd10;
        rows.push_back(row);
        row.word.cmd = 4'd15;
        rows.push_back(row);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[n]) begin
            if ($urandom_range(2) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 90)) @(negedge i_clk);
            end
            send_word(rows[n].word, rows[n].has_status, rows[n].status);
        end

        // Random part: alternate filling and draining so the table reaches full.
        draining = 1'b0;
        burst    = 0;
        for (int n = 0; n < NumRandom; n++) begin
            if (n % 250 == 0) draining = !draining && (n != 0);
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 120)) @(negedge i_clk);
                end
            end
            burst--;
            w = random_word(draining);
            send_word(w, 1'b0, S_OK);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
